/* sv/ult_pkg.sv */
// Shared widths, command and status codes, and cell control bundle for the list table.
package ult_pkg;

   localparam int CMD_W  = 3;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 6;
   localparam int STAT_W = 3;
   localparam int CNT_W  = 7;

   localparam logic [CNT_W-1:0] CAP_RESET = 7'd50;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_READ   = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_DUP      = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_NOTFOUND = 3'd4,
      STAT_BOUNDS   = 3'd5
   } status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             compare;
      logic             load;
      logic             shift;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] hit_idx;
      logic [POS_W-1:0] position;
   } cell_ctrl_type;

endpackage

/* sv/ult_ifs.sv */
// Handshake channels of the list table: request, response and capacity write.
interface ult_req_if import ult_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [VAL_W-1:0] value;
   logic [POS_W-1:0] position;
   modport source (output valid, cmd, value, position, input ready);
   modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface ult_rsp_if import ult_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [VAL_W-1:0]  read_value;
   logic [POS_W-1:0]  found_index;
   logic [CNT_W-1:0]  entry_count;
   logic              is_empty;
   logic              is_full;
   modport source (output valid, status, read_value, found_index, entry_count, is_empty,
                   is_full, input ready);
   modport sink   (input valid, status, read_value, found_index, entry_count, is_empty,
                   is_full, output ready);
endinterface

interface ult_csr_if import ult_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* sv/ult_cell.sv */
// One table slot: holds an entry, compares it locally and takes its neighbor's entry on delete.
module ult_cell import ult_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [IDX_W-1:0]    idx,
   input  logic [WIDTH-1:0]    key,
   input  logic [WIDTH-1:0]    next_entry,
   output logic [WIDTH-1:0]    entry,
   output logic                match,
   output logic                sel
);

   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   logic [WIDTH-1:0] entry_ff, entry_in;
   logic             match_ff, match_in;
   logic             sel_ff, sel_in;
   logic [CMP_W-1:0] idx_x, cnt_x, hit_x, pos_x;
   logic             in_use;

   always_comb begin
      idx_x  = CMP_W'(idx);
      cnt_x  = CMP_W'(ctrl.count);
      hit_x  = CMP_W'(ctrl.hit_idx);
      pos_x  = CMP_W'(ctrl.position);
      in_use = idx_x < cnt_x;

      entry_in = entry_ff;
      if (ctrl.load && idx_x == cnt_x) begin
         entry_in = key;
      end else if (ctrl.shift && idx_x >= hit_x) begin
         entry_in = next_entry;
      end

      match_in = match_ff;
      sel_in   = sel_ff;
      if (ctrl.compare) begin
         match_in = in_use && (entry_ff == key);
         sel_in   = in_use && (idx_x == pos_x);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
      sel_ff   <= sel_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;
   assign sel   = sel_ff;

endmodule

/* sv/unsorted_list_table.sv */
// Top level of the list table: command controller, response register and the row of cells.
//
// Unsorted list table. Keeps up to an effective capacity of distinct values in
// arrival order plus an entry count; commands are insert, delete, read at
// position, find and clear, and each request yields exactly one response with
// status, count and empty/full flags. The table is a row of DEPTH cells, each
// holding one entry. A request is accepted, then evaluated: in the accept cycle
// every cell compares its entry against the request value (and its own index
// against the read position) and registers the result; in the evaluation state
// the match and select bits are OR-reduced, the status is formed, the response
// register is loaded and the row is updated (insert writes the cell at the
// count, delete has every cell at or above the hit take its upper neighbor's
// entry). A new request is taken only in idle, after the last one's evaluation.
// The response has its own register, so the next request is accepted while a
// response still waits; the block stays in evaluation only while that register
// is full and not taken. Capacity (csr) is saturated into 1..DEPTH
// (and to 127 by its width); lowering it below the count leaves entries in
// place and reports full. Entries need no reset and there is no clearing pass:
// only cells below the count are ever compared or read. VALUE_WIDTH above 32
// stores 32 bits, since the request value carries no more.
module unsorted_list_table import ult_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ult_req_if.sink    req_ch,
   ult_rsp_if.source  rsp_ch,
   ult_csr_if.sink    csr_ch
);

   localparam int STORE_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

   typedef enum logic {S_IDLE, S_EVAL} state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [STORE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [VAL_W-1:0]    read_value_ff, read_value_in;
   logic [POS_W-1:0]    found_index_ff, found_index_in;
   logic [CNT_W-1:0]    entry_count_ff;
   logic                is_empty_ff, is_empty_in;
   logic                is_full_ff, is_full_in;

   logic                req_accept;
   logic                eval_done;
   logic [CNT_W-1:0]    cap_eff;
   logic [STORE_W-1:0]  key;
   cell_ctrl_type       ctrl;

   logic [STORE_W-1:0]  entry_vec [DEPTH];
   logic [DEPTH-1:0]    match_vec;
   logic [DEPTH-1:0]    sel_vec;
   logic                hit;
   logic [IDX_W-1:0]    hit_or;
   logic [CNT_W-1:0]    hit_idx;
   logic [STORE_W-1:0]  rd_or;
   logic                do_load, do_shift;
   status_type          status_val;

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   // the response slot frees up this cycle if empty or being taken
   assign eval_done    = (state_ff == S_EVAL) && (!rsp_valid_ff || rsp_ch.ready);

   // saturate capacity into 1..CAP_MAX
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ff > CNT_W'(CAP_MAX)) begin
         cap_eff = CNT_W'(CAP_MAX);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // OR-reduce cell outputs; entries are distinct, so at most one match
   always_comb begin
      hit_or = '0;
      rd_or  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_or = hit_or | (match_vec[i] ? IDX_W'(i) : '0);
         rd_or  = rd_or | (sel_vec[i] ? entry_vec[i] : '0);
      end
      hit     = |match_vec;
      hit_idx = CNT_W'(hit_or);
   end

   // command decode in the evaluation state
   always_comb begin
      status_val     = STAT_OK;
      do_load        = 1'b0;
      do_shift       = 1'b0;
      count_in       = count_ff;
      read_value_in  = '0;
      found_index_in = '0;
      case (cmd_ff)
         CMD_INSERT: begin
            if (count_ff >= cap_eff) begin
               status_val = STAT_FULL;
            end else if (hit) begin
               status_val = STAT_DUP;
            end else begin
               do_load  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (count_ff == '0) begin
               status_val = STAT_EMPTY;
            end else if (!hit) begin
               status_val = STAT_NOTFOUND;
            end else begin
               do_shift = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (CNT_W'(pos_ff) >= count_ff) begin
               status_val = STAT_BOUNDS;
            end else begin
               read_value_in = VAL_W'(rd_or);
            end
         end
         CMD_FIND: begin
            if (hit) begin
               found_index_in = POS_W'(hit_idx);
            end else begin
               status_val = STAT_NOTFOUND;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      status_in   = status_val;
      is_empty_in = (count_in == '0);
      is_full_in  = (count_in >= cap_eff);
   end

   // next-state and response register inputs
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      cap_in       = csr_ch.valid ? csr_ch.data : cap_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (eval_done) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_ch.cmd;
         value_ff <= STORE_W'(req_ch.value);
         pos_ff   <= req_ch.position;
      end
      if (eval_done) begin
         status_ff      <= status_in;
         read_value_ff  <= read_value_in;
         found_index_ff <= found_index_in;
         entry_count_ff <= count_in;
         is_empty_ff    <= is_empty_in;
         is_full_ff     <= is_full_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (eval_done) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.read_value  = read_value_ff;
   assign rsp_ch.found_index = found_index_ff;
   assign rsp_ch.entry_count = entry_count_ff;
   assign rsp_ch.is_empty    = is_empty_ff;
   assign rsp_ch.is_full     = is_full_ff;

   // cell control: compare on accept, update when the response is written
   assign key = (state_ff == S_IDLE) ? STORE_W'(req_ch.value) : value_ff;

   always_comb begin
      ctrl.compare  = req_accept;
      ctrl.load     = eval_done && do_load;
      ctrl.shift    = eval_done && do_shift;
      ctrl.count    = count_ff;
      ctrl.hit_idx  = hit_idx;
      ctrl.position = req_ch.position;
   end

   // row of cells; each passes its entry down to the cell below
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [STORE_W-1:0] upper;
      if (g == DEPTH - 1) begin : g_top
         assign upper = entry_vec[g];
      end else begin : g_mid
         assign upper = entry_vec[g+1];
      end
      ult_cell #(
         .WIDTH (STORE_W),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (IDX_W'(g)),
         .key        (key),
         .next_entry (upper),
         .entry      (entry_vec[g]),
         .match      (match_vec[g]),
         .sel        (sel_vec[g])
      );
   end

   // the table never holds a value twice
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> $onehot0(match_vec))
      else $error("more than one cell matched");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAP_MAX))
      else $error("entry count above capacity limit");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EVAL))
      else $error("accepted request not evaluated");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EVAL))
      else $error("response raised outside evaluation");

   a_count_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> $past(eval_done))
      else $error("count changed without a completed request");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the unsorted list table: random and directed requests.
`timescale 1ns / 100ps

module testbench;
   import ult_pkg::*;

   // Table geometry as built into the block, and the unused command codes
   // that must answer as a no-op.
   localparam int TABLE_DEPTH = 64;
   localparam int POOL_SIZE   = 72;
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
   localparam int NOT_PRESENT = -1;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
   } request_type;

   typedef struct {
      status_type       status;
      logic [VAL_W-1:0] read_value;
      logic [POS_W-1:0] found_index;
      logic [CNT_W-1:0] entry_count;
      logic             is_empty;
      logic             is_full;
   } table_result_type;

   logic clock;
   logic reset;

   ult_req_if req_bus ();
   ult_rsp_if rsp_bus ();
   ult_csr_if csr_bus ();

   unsorted_list_table uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the table: values in arrival order, count and capacity.
   logic [VAL_W-1:0] table_vals [TABLE_DEPTH];
   int unsigned      table_count;
   logic [CNT_W-1:0] capacity_reg;

   request_type      pending_requests [$];
   table_result_type expected_responses [$];
   logic [VAL_W-1:0] value_pool [POOL_SIZE];

   int  req_issued;     // driver side, blocking
   int  req_taken;      // handshake side, updated at the rising edge
   int  csr_writes;
   int  mismatches;
   int  send_gap;
   int  stall_left;
   bit  steady;         // no idling on either side when set

   // Capacity as the block applies it: saturated into 1..DEPTH.
   function automatic int unsigned active_capacity();
      if (capacity_reg == 0)
         return 1;
      if (capacity_reg > TABLE_DEPTH)
         return TABLE_DEPTH;
      return capacity_reg;
   endfunction

   function automatic int locate_value(logic [VAL_W-1:0] value);
      for (int i = 0; i < table_count; i++) begin
         if (table_vals[i] == value)
            return i;
      end
      return NOT_PRESENT;
   endfunction

   // Applies one request to the shadow table and returns the response it owes.
   function automatic table_result_type apply_table_request(request_type req);
      table_result_type res;
      int unsigned      cap;
      int               slot;
      cap             = active_capacity();
      res.status      = STAT_OK;
      res.read_value  = '0;
      res.found_index = '0;
      case (req.cmd)
         CMD_INSERT: begin
            // full check wins over the duplicate check
            if (table_count >= cap)
               res.status = STAT_FULL;
            else if (locate_value(req.value) != NOT_PRESENT)
               res.status = STAT_DUP;
            else begin
               table_vals[table_count] = req.value;
               table_count++;
            end
         end
         CMD_DELETE: begin
            slot = locate_value(req.value);
            if (table_count == 0)
               res.status = STAT_EMPTY;
            else if (slot == NOT_PRESENT)
               res.status = STAT_NOTFOUND;
            else begin
               for (int i = slot; i + 1 < table_count; i++)
                  table_vals[i] = table_vals[i + 1];
               table_count--;
            end
         end
         CMD_READ: begin
            // an empty table puts every position out of bounds
            if (req.position >= table_count)
               res.status = STAT_BOUNDS;
            else
               res.read_value = table_vals[req.position];
         end
         CMD_FIND: begin
            slot = locate_value(req.value);
            if (slot == NOT_PRESENT)
               res.status = STAT_NOTFOUND;
            else
               res.found_index = slot[POS_W-1:0];
         end
         CMD_CLEAR: begin
            table_count = 0;
         end
         default: begin
            // spare codes: no operation
         end
      endcase
      res.entry_count = table_count[CNT_W-1:0];
      res.is_empty    = (table_count == 0);
      res.is_full     = (table_count >= cap);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: one request held until taken, random gaps between them.
   always @(negedge clock) begin : request_driver
      request_type next_req;
      if (req_issued == req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            if (!steady && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_bus.valid <= 1'b0;
            end else begin
               next_req = pending_requests.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.cmd      <= next_req.cmd;
               req_bus.value    <= next_req.value;
               req_bus.position <= next_req.position;
               req_issued++;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: predicts on every taken request, checks every response in order,
   // and follows capacity writes.
   always @(posedge clock) begin : monitor
      request_type      taken;
      table_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken.cmd      = req_bus.cmd;
            taken.value    = req_bus.value;
            taken.position = req_bus.position;
            expected_responses.push_back(apply_table_request(taken));
            req_taken <= req_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_responses.pop_front();
               check_field("status",      want.status,      rsp_bus.status);
               check_field("read_value",  want.read_value,  rsp_bus.read_value);
               check_field("found_index", want.found_index, rsp_bus.found_index);
               check_field("entry_count", want.entry_count, rsp_bus.entry_count);
               check_field("is_empty",    want.is_empty,    rsp_bus.is_empty);
               check_field("is_full",     want.is_full,     rsp_bus.is_full);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            capacity_reg = csr_bus.data;
            csr_writes <= csr_writes + 1;
         end
      end
   end

   task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                                input logic [POS_W-1:0] position);
      request_type req;
      req.cmd      = cmd;
      req.value    = value;
      req.position = position;
      pending_requests.push_back(req);
   endtask

   // Holds the sender until every request is issued and taken and every response is back.
   task automatic settle();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_issued != req_taken ||
             expected_responses.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      int target;
      @(negedge clock);
      target       = csr_writes + 1;
      csr_bus.valid = 1'b1;
      csr_bus.data  = cap;
      while (csr_writes != target)
         @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Mostly values from the shared pool so inserts collide and deletes/finds hit.
   function automatic logic [VAL_W-1:0] pick_value(int span);
      if ($urandom_range(0, 19) == 0)
         return $urandom();
      return value_pool[$urandom_range(0, span - 1)];
   endfunction

   task automatic run_phase(input logic [CNT_W-1:0] cap_setting, input int n_items,
                            input int insert_pct);
      int               cap_eff;
      int               span;
      int               roll;
      int               read_top;
      logic [POS_W-1:0] pos;
      write_capacity(cap_setting);
      cap_eff  = (cap_setting == 0) ? 1 : (cap_setting > TABLE_DEPTH) ? TABLE_DEPTH
                                                                      : cap_setting;
      span     = (cap_eff + 4 > POOL_SIZE) ? POOL_SIZE : cap_eff + 4;
      read_top = (cap_eff + 1 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : cap_eff + 1;
      @(posedge clock);
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         pos  = POS_W'($urandom_range(0, TABLE_DEPTH - 1));
         if (roll < insert_pct)
            queue_request(CMD_INSERT, pick_value(span), pos);
         else if (roll < insert_pct + 20)
            queue_request(CMD_DELETE, pick_value(span), pos);
         else if (roll < insert_pct + 38) begin
            if ($urandom_range(0, 6) != 0)
               pos = POS_W'($urandom_range(0, read_top));
            queue_request(CMD_READ, $urandom(), pos);
         end else if (roll < 97)
            queue_request(CMD_FIND, pick_value(span), pos);
         else if (roll < 98)
            queue_request(CMD_CLEAR, $urandom(), pos);
         else
            queue_request(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                          $urandom(), pos);
      end
      settle();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.cmd    = CMD_INSERT;
      req_bus.value  = '0;
      req_bus.position = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = '0;
      capacity_reg   = CAP_RESET;
      table_count    = 0;
      req_issued     = 0;
      req_taken      = 0;
      csr_writes     = 0;
      mismatches     = 0;
      send_gap       = 0;
      stall_left     = 0;
      steady         = 1'b0;
      foreach (value_pool[i])
         value_pool[i] = $urandom();
      value_pool[3] = '0;
      value_pool[5] = '1;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset capacity: empty-table corner cases first,
      // then duplicates, bounds, delete with shift and the spare codes.
      @(posedge clock);
      queue_request(CMD_FIND,   32'h0000_0005, '0);   // empty: not found
      queue_request(CMD_READ,   '0,            '0);   // empty: out of bounds
      queue_request(CMD_DELETE, 32'h0000_0005, '0);   // empty: empty status
      queue_request(CMD_INSERT, 32'h0000_0000, '1);
      queue_request(CMD_INSERT, 32'hFFFF_FFFF, '0);
      queue_request(CMD_INSERT, 32'h0000_0000, '0);   // duplicate
      queue_request(CMD_INSERT, 32'h1234_5678, '0);
      queue_request(CMD_READ,   '0,            6'd0);
      queue_request(CMD_READ,   '1,            6'd2);
      queue_request(CMD_READ,   '0,            6'd3); // one past the end
      queue_request(CMD_READ,   '0,            '1);
      queue_request(CMD_FIND,   32'hFFFF_FFFF, '0);
      queue_request(CMD_FIND,   32'h0000_DEAD, '0);
      queue_request(CMD_DELETE, 32'h0000_DEAD, '0);
      queue_request(CMD_DELETE, 32'h0000_0000, '0);   // later entries shift down
      queue_request(CMD_READ,   '0,            6'd0);
      queue_request(CMD_READ,   '0,            6'd1);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         queue_request(CMD_W'(c), $urandom(), POS_W'($urandom()));
      queue_request(CMD_CLEAR,  '0,            '0);
      queue_request(CMD_READ,   '0,            6'd0);
      queue_request(CMD_INSERT, 32'hA5A5_A5A5, '0);
      queue_request(CMD_INSERT, 32'h5A5A_5A5A, '0);
      queue_request(CMD_INSERT, 32'h0000_0001, '0);
      settle();

      // Capacity dropped under the count: entries stay, table reports full.
      write_capacity(7'd2);
      @(posedge clock);
      queue_request(CMD_INSERT, 32'h0000_0077, '0);
      queue_request(CMD_READ,   '0,            6'd2);
      queue_request(CMD_DELETE, 32'hA5A5_A5A5, '0);
      queue_request(CMD_INSERT, 32'h0000_0077, '0);
      queue_request(CMD_FIND,   32'h5A5A_5A5A, '0);
      settle();

      // Capacity zero acts as one; a full table holding the value says full.
      write_capacity(7'd0);
      @(posedge clock);
      queue_request(CMD_CLEAR,  '0,            '0);
      queue_request(CMD_INSERT, 32'h0000_0007, '0);
      queue_request(CMD_INSERT, 32'h0000_0007, '0);
      queue_request(CMD_INSERT, 32'h0000_0009, '0);
      queue_request(CMD_FIND,   32'h0000_0007, '0);
      settle();

      // Random phases over a sweep of capacities, extremes included; the
      // drain between phases also covers the sender waiting on the block.
      run_phase(7'd127, 90, 60);   // saturates at full depth
      run_phase(7'd8,   70, 30);   // starts well above capacity
      run_phase(7'd0,   40, 35);
      run_phase(7'd64,  80, 50);
      run_phase(7'd3,   60, 35);
      run_phase(7'd1,   40, 35);
      run_phase(7'd33,  70, 40);
      steady = 1'b1;
      run_phase(CAP_RESET, 70, 40);

      repeat (4) @(negedge clock);
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #4000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
